### hdl/scalar_kalman_smoother_defines.svh
// ----------------------------------------------------------------------------
// scalar_kalman_smoother_defines.svh
// assertion macros shared by the smoother checker
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_SMOOTHER_DEFINES_SVH
`define SCALAR_KALMAN_SMOOTHER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SKS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg
// widths, register indexes, reset values and sequencer types of the smoother
// ----------------------------------------------------------------------------
package sks_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int FRAC_BITS   = 16;
	localparam int EST_BITS    = SAMPLE_BITS + FRAC_BITS;
	localparam int ERR_BITS    = 32;
	localparam int GAIN_BITS   = 16;
	localparam int PN_BITS     = 16;

	// shared multiplier operand widths (estimate fits the wide operand)
	localparam int MUL_A_BITS  = GAIN_BITS + 1;
	localparam int MUL_B_BITS  = ERR_BITS;
	localparam int MUL_P_BITS  = MUL_A_BITS + MUL_B_BITS;

	// divider produces one quotient bit per step, quotient is at most 1.0
	localparam int DIV_STEPS    = GAIN_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MEAS_NOISE    = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PROCESS_NOISE = 1'b1;

	localparam logic [ERR_BITS-1:0] MEAS_RESET = 32'd131072;
	localparam logic [PN_BITS-1:0]  PROC_RESET = 16'd655;
	localparam logic [ERR_BITS-1:0] ERR_RESET  = 32'd131072;
	localparam logic [MUL_A_BITS-1:0] ONE_Q16  = MUL_A_BITS'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		MUL_MOVE,
		MUL_KEEP,
		MUL_PROC
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MOVE,
		ST_KEEP,
		ST_PROC,
		ST_UPD,
		ST_DONE
	} state_t;

endpackage

### hdl/scalar_kalman_smoother.sv
// ----------------------------------------------------------------------------
// scalar_kalman_smoother
// one-dimensional kalman smoother for 12-bit converter samples
//
// input channel: sample with sample_valid / sample_stall, a beat moves when
//   valid is high and stall is low; stall stays high while a sample is worked
// output channel: filtered with filtered_valid / filtered_stall, one result
//   beat per sample, held in an output register until the receiver takes it
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data, always
//   ready; index 0 is measurement noise (q16.16), index 1 process noise (q0.16)
// work per sample is dominated by the 17-step serial gain divider plus three
//   passes through one shared multiplier
// a new sample is taken only once the previous one has reached the output register
// a stalled receiver holds the result; the next sample is still taken and
//   worked, and its result waits until the output register is free
// reset: estimate clears to zero, error estimate to 2.0, noise registers to
//   their defaults (2.0 and about 0.01)
// ----------------------------------------------------------------------------
module scalar_kalman_smoother (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  logic [sks_pkg::SAMPLE_BITS-1:0]  sample,
	output logic                             filtered_valid,
	input  logic                             filtered_stall,
	output logic [sks_pkg::SAMPLE_BITS-1:0]  filtered,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sks_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [sks_pkg::ERR_BITS-1:0]     cfg_data
);

	sks_pkg::state_t state_q, state_d;
	sks_pkg::mul_op_t mul_op;

	// filter state and configuration
	logic [sks_pkg::ERR_BITS-1:0]   meas_q;
	logic [sks_pkg::PN_BITS-1:0]    pn_q;
	logic [sks_pkg::EST_BITS-1:0]   est_q;
	logic [sks_pkg::ERR_BITS-1:0]   err_q;

	// per-sample working registers
	logic                           up_q;
	logic [sks_pkg::EST_BITS-1:0]   mag_q;
	logic [sks_pkg::EST_BITS-1:0]   move_q;
	logic [sks_pkg::ERR_BITS:0]     term1_q;
	logic [sks_pkg::SAMPLE_BITS-1:0] filtered_q;
	logic                           out_valid_q;

	logic                           accept;
	logic                           out_free;
	logic                           div_done;
	logic [sks_pkg::GAIN_BITS-1:0]  gain;
	logic [sks_pkg::MUL_P_BITS-1:0] prod;
	logic [sks_pkg::EST_BITS-1:0]   target;
	logic [sks_pkg::EST_BITS-1:0]   term2;
	logic [sks_pkg::ERR_BITS+1:0]   err_sum;

	assign accept   = sample_valid && !sample_stall;
	assign out_free = !out_valid_q || !filtered_stall;
	assign target   = {sample, sks_pkg::FRAC_BITS'(0)};
	assign term2    = prod[sks_pkg::FRAC_BITS +: sks_pkg::EST_BITS];
	assign err_sum  = {1'b0, term1_q} + (sks_pkg::ERR_BITS+2)'(term2);

	// gain divider, started by the accepted sample beat
	sks_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.err    (err_q),
		.meas   (meas_q),
		.gain   (gain),
		.done   (div_done)
	);

	// one multiplier: gain*|diff|, (1-gain)*error, |move|*process noise
	sks_mul u_mul (
		.clk  (clk),
		.op   (mul_op),
		.gain (gain),
		.mag  (mag_q),
		.err  (err_q),
		.move (move_q),
		.pn   (pn_q),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sks_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mul_op       = sks_pkg::MUL_MOVE;
		sample_stall = 1'b1;
		unique case (state_q)
			sks_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					state_d = sks_pkg::ST_DIV;
				end
			end
			sks_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = sks_pkg::ST_MOVE;
				end
			end
			sks_pkg::ST_MOVE: begin
				mul_op  = sks_pkg::MUL_MOVE;
				state_d = sks_pkg::ST_KEEP;
			end
			sks_pkg::ST_KEEP: begin
				mul_op  = sks_pkg::MUL_KEEP;
				state_d = sks_pkg::ST_PROC;
			end
			sks_pkg::ST_PROC: begin
				mul_op  = sks_pkg::MUL_PROC;
				state_d = sks_pkg::ST_UPD;
			end
			sks_pkg::ST_UPD: begin
				state_d = sks_pkg::ST_DONE;
			end
			sks_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = sks_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sks_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration, filter state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_q      <= sks_pkg::MEAS_RESET;
			pn_q        <= sks_pkg::PROC_RESET;
			est_q       <= '0;
			err_q       <= sks_pkg::ERR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sks_pkg::REG_MEAS_NOISE:    meas_q <= cfg_data;
					sks_pkg::REG_PROCESS_NOISE: pn_q   <= cfg_data[sks_pkg::PN_BITS-1:0];
					default: ;
				endcase
			end
			if (state_q == sks_pkg::ST_UPD) begin
				// move rounds toward zero, so the estimate never passes the sample
				est_q <= up_q ? est_q + move_q : est_q - move_q;
				// error saturates at full scale
				err_q <= (|err_sum[sks_pkg::ERR_BITS+1:sks_pkg::ERR_BITS]) ? '1
					: err_sum[sks_pkg::ERR_BITS-1:0];
			end
			if (state_q == sks_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!filtered_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			up_q  <= target >= est_q;
			mag_q <= (target >= est_q) ? target - est_q : est_q - target;
		end
		if (state_q == sks_pkg::ST_KEEP) begin
			move_q <= prod[sks_pkg::FRAC_BITS +: sks_pkg::EST_BITS];
		end
		if (state_q == sks_pkg::ST_PROC) begin
			term1_q <= prod[sks_pkg::FRAC_BITS +: sks_pkg::ERR_BITS+1];
		end
		if (state_q == sks_pkg::ST_DONE && out_free) begin
			filtered_q <= est_q[sks_pkg::FRAC_BITS +: sks_pkg::SAMPLE_BITS];
		end
	end

	assign cfg_ready      = 1'b1;
	assign filtered_valid = out_valid_q;
	assign filtered       = filtered_q;

endmodule

### hdl/sks_div.sv
// ----------------------------------------------------------------------------
// sks_div
// restoring serial divider for the gain, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sks_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [sks_pkg::ERR_BITS-1:0]   err,
	input  logic [sks_pkg::ERR_BITS-1:0]   meas,
	output logic [sks_pkg::GAIN_BITS-1:0]  gain,
	output logic                           done
);

	logic [sks_pkg::ERR_BITS:0]         den_q;
	logic [sks_pkg::ERR_BITS:0]         rem_q;
	logic                               nb_q;
	logic [sks_pkg::DIV_STEPS-1:0]      quo_q;
	logic [sks_pkg::DIV_CNT_BITS-1:0]   cnt_q;
	logic                               busy_q;
	logic                               done_q;
	logic [sks_pkg::ERR_BITS+1:0]       trial;
	logic [sks_pkg::ERR_BITS+1:0]       diff;
	logic                               ge;

	assign trial = {rem_q, nb_q};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= sks_pkg::DIV_CNT_BITS'(sks_pkg::DIV_STEPS);
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - sks_pkg::DIV_CNT_BITS'(1);
			if (cnt_q == sks_pkg::DIV_CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder starts at err/2, err lsb is the first bit shifted in
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= {1'b0, err} + {1'b0, meas};
			rem_q <= {2'b00, err[sks_pkg::ERR_BITS-1:1]};
			nb_q  <= err[0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[sks_pkg::ERR_BITS:0] : trial[sks_pkg::ERR_BITS:0];
			nb_q  <= 1'b0;
			quo_q <= {quo_q[sks_pkg::DIV_STEPS-2:0], ge};
		end
	end

	// empty denominator gives zero, a full 1.0 saturates just below
	always_comb begin
		priority if (den_q == '0) begin
			gain = '0;
		end else if (quo_q[sks_pkg::DIV_STEPS-1]) begin
			gain = '1;
		end else begin
			gain = quo_q[sks_pkg::GAIN_BITS-1:0];
		end
	end

	assign done = done_q;

endmodule

### hdl/sks_mul.sv
// ----------------------------------------------------------------------------
// sks_mul
// shared multiplier with operand select and registered product
// ----------------------------------------------------------------------------
module sks_mul (
	input  logic                            clk,
	input  sks_pkg::mul_op_t                op,
	input  logic [sks_pkg::GAIN_BITS-1:0]   gain,
	input  logic [sks_pkg::EST_BITS-1:0]    mag,
	input  logic [sks_pkg::ERR_BITS-1:0]    err,
	input  logic [sks_pkg::EST_BITS-1:0]    move,
	input  logic [sks_pkg::PN_BITS-1:0]     pn,
	output logic [sks_pkg::MUL_P_BITS-1:0]  prod
);

	logic [sks_pkg::MUL_A_BITS-1:0] a;
	logic [sks_pkg::MUL_B_BITS-1:0] b;
	logic [sks_pkg::MUL_P_BITS-1:0] prod_q;

	always_comb begin
		unique case (op)
			sks_pkg::MUL_MOVE: begin
				a = sks_pkg::MUL_A_BITS'(gain);
				b = sks_pkg::MUL_B_BITS'(mag);
			end
			sks_pkg::MUL_KEEP: begin
				// one minus gain, never zero since gain stays below 1.0
				a = sks_pkg::ONE_Q16 - sks_pkg::MUL_A_BITS'(gain);
				b = err;
			end
			sks_pkg::MUL_PROC: begin
				a = sks_pkg::MUL_A_BITS'(pn);
				b = sks_pkg::MUL_B_BITS'(move);
			end
			default: begin
				a = '0;
				b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= sks_pkg::MUL_P_BITS'(a) * sks_pkg::MUL_P_BITS'(b);
	end

	assign prod = prod_q;

endmodule

### hdl/sks_checker.sv
// ----------------------------------------------------------------------------
// sks_checker
// port-level checks on the smoother channels, bound to the top level
// ----------------------------------------------------------------------------
`include "scalar_kalman_smoother_defines.svh"

module sks_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             sample_valid,
	input logic                             sample_stall,
	input logic                             filtered_valid,
	input logic                             filtered_stall,
	input logic [sks_pkg::SAMPLE_BITS-1:0]  filtered
);

	logic out_wait;
	logic in_beat;

	assign out_wait = filtered_valid && filtered_stall;
	assign in_beat  = sample_valid && !sample_stall;

	// a result beat is held while the receiver stalls
	`SKS_ASSERT_NEXT(a_out_hold, out_wait, filtered_valid, "result dropped under stall")

	`SKS_ASSERT_NEXT(a_out_stable, out_wait, $stable(filtered), "result changed under stall")

	// a sample beat makes the block busy in the next cycle
	`SKS_ASSERT_NEXT(a_busy_after_beat, in_beat, sample_stall, "sample taken while busy")

	// a new result only shows up after a sample has been worked
	`SKS_ASSERT_NOW(a_result_from_work, $rose(filtered_valid), $past(sample_stall), "stray result")

endmodule

bind scalar_kalman_smoother sks_checker u_sks_checker (.*);
